/* hw/rtl/assert_macros.svh */
// Assertion macros used by the RTL of the hash table block.
// Each macro expands to a clocked concurrent assertion, or to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// The property must hold at every rising edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// The expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_AT(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

/* hw/rtl/lpht_pkg.sv */
// Package for the linear probing hash table: field widths, codes and state type.
// No dependencies.
`default_nettype none

package lpht_pkg;

    localparam int KEY_W  = 32;
    localparam int CFG_W  = 8;
    localparam int ACT_W  = 2;
    localparam int OUT_W  = 2;
    localparam int SLOT_W = 7;
    localparam int ST_W   = 2;
    localparam int BIT_W  = 5;

    localparam logic [CFG_W-1:0] CFG_RESET = 8'd128;

    // Request codes.
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

    // Slot status codes.
    localparam logic [ST_W-1:0] ST_EMPTY    = 2'd0;
    localparam logic [ST_W-1:0] ST_OCCUPIED = 2'd1;
    localparam logic [ST_W-1:0] ST_REMOVED  = 2'd2;

    // Result codes.
    localparam logic [OUT_W-1:0] OUT_OK        = 2'd0;
    localparam logic [OUT_W-1:0] OUT_NOT_FOUND = 2'd1;
    localparam logic [OUT_W-1:0] OUT_FULL      = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIVIDE,
        S_FIXUP,
        S_PROBE,
        S_FINISH
    } state_t;

endpackage

`default_nettype wire

/* hw/rtl/linear_probe_hash_table.sv */
// Top level of the linear probing hash table: sequencer, remainder unit and slot memory.
// Depends on lpht_pkg and assert_macros.svh.
//
// Usage:
// One request beat on the input channel (action, key) yields exactly one result beat
// on the output channel (outcome, slot_index). Action 0 inserts, 1 searches, 2 removes;
// the unused code answers "not found" with slot 0 and changes nothing.
// The home slot is the non-negative remainder of the signed key modulo the active
// size, computed by a restoring remainder unit, one key bit per cycle.
// Probing then reads the slot memory one slot per cycle through its read port.
// An accepted request passes through S_DIVIDE, S_FIXUP, S_PROBE (probing 1 up to the
// active size of slots) and S_FINISH before out_valid rises; the unused code goes
// straight to S_FINISH. The next request is taken once the block is back in S_IDLE.
// After reset the block runs a clearing pass over all TABLE_DEPTH slots, one slot per
// cycle, and accepts no request during the pass; configuration writes are taken at all
// times. table_size resets to 128.
// A finished result sits in an output register. The next request is accepted while
// it waits; if the receiver stalls, that next request finishes its work and then
// holds in its last step until the output register is free.
`default_nettype none
`include "assert_macros.svh"

module linear_probe_hash_table
    import lpht_pkg::*;
#(
    parameter int TABLE_DEPTH = 128
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // Configuration: the one register, table_size.
    input  wire logic                    cfg_write,
    input  wire logic [CFG_W-1:0]        cfg_data,
    // Request channel.
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [ACT_W-1:0]        action,
    input  wire logic signed [KEY_W-1:0] key,
    // Result channel.
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [OUT_W-1:0]             outcome,
    output logic [SLOT_W-1:0]            slot_index
);

    // Slot index width and a compare width wide enough for both indexes and sizes.
    localparam int IDX_W    = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
    localparam int WIDE_W   = (IDX_W > CFG_W) ? IDX_W : CFG_W;
    localparam int CNT_W    = WIDE_W + 1;
    localparam int WORD_W   = KEY_W + ST_W;
    localparam int SIZE_CAP_I = (TABLE_DEPTH < 255) ? TABLE_DEPTH : 255;
    localparam logic [CFG_W-1:0] SIZE_CAP  = CFG_W'(SIZE_CAP_I);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_DEPTH - 1);

    // Control state.
    state_t              state_reg, state_next;
    logic [CFG_W-1:0]    table_size_reg;
    logic [IDX_W-1:0]    clr_reg, clr_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic                out_valid_reg, out_valid_next;

    // Request and working registers.
    logic [ACT_W-1:0]    action_reg, action_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic                neg_reg, neg_next;
    logic [KEY_W-1:0]    div_reg, div_next;
    logic [CFG_W-1:0]    rem_reg, rem_next;
    logic [IDX_W-1:0]    j_reg, j_next;
    logic [OUT_W-1:0]    res_outcome_reg, res_outcome_next;
    logic [IDX_W-1:0]    res_slot_reg, res_slot_next;
    logic [OUT_W-1:0]    outcome_reg, outcome_next;
    logic [SLOT_W-1:0]   slot_index_reg, slot_index_next;

    // Slot memory: status above key in one word, read and write ports, registered read.
    logic [WORD_W-1:0]   slot_mem [TABLE_DEPTH];
    logic [WORD_W-1:0]   rd_q;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [WORD_W-1:0]   mem_wdata;

    logic [CFG_W-1:0]    m_size;
    logic                in_fire;
    logic [KEY_W-1:0]    key_u;
    logic [CFG_W:0]      rem_trial;
    logic [CFG_W-1:0]    home_slot;
    logic [IDX_W-1:0]    j_adv;
    logic                last_probe;
    logic [ST_W-1:0]     rd_status;
    logic [KEY_W-1:0]    rd_key;
    logic                probe_done;
    logic                probe_write;
    logic [ST_W-1:0]     probe_wstatus;
    logic [OUT_W-1:0]    probe_outcome;
    logic                out_free;

    // A size of zero acts as one; a size beyond the memory acts as the memory depth.
    always_comb
    begin
        if (table_size_reg == '0)
        begin
            m_size = CFG_W'(1);
        end
        else if (table_size_reg > SIZE_CAP)
        begin
            m_size = SIZE_CAP;
        end
        else
        begin
            m_size = table_size_reg;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign key_u     = key;
    assign out_free  = !out_valid_reg || out_ready;

    // One step of the restoring remainder: shift in the next key bit, subtract if it fits.
    assign rem_trial = {rem_reg, div_reg[KEY_W-1]};

    // The remainder of the magnitude is folded back for negative keys.
    assign home_slot = (neg_reg && (rem_reg != '0)) ? (m_size - rem_reg) : rem_reg;

    // Next slot along the probe path, wrapping at the active size.
    assign j_adv      = ((CNT_W'(j_reg) + CNT_W'(1)) >= CNT_W'(m_size)) ?
                        '0 : (j_reg + IDX_W'(1));
    assign last_probe = ((n_reg + CNT_W'(1)) >= CNT_W'(m_size));

    assign rd_status = rd_q[KEY_W +: ST_W];
    assign rd_key    = rd_q[KEY_W-1:0];

    // Decision for the slot held in rd_q, which belongs to j_reg while probing.
    always_comb
    begin
        probe_done    = 1'b0;
        probe_write   = 1'b0;
        probe_wstatus = ST_OCCUPIED;
        probe_outcome = OUT_NOT_FOUND;
        if (action_reg == ACT_INSERT)
        begin
            if (rd_status == ST_EMPTY)
            begin
                probe_done    = 1'b1;
                probe_write   = 1'b1;
                probe_wstatus = ST_OCCUPIED;
                probe_outcome = OUT_OK;
            end
            else if (last_probe)
            begin
                probe_done    = 1'b1;
                probe_outcome = OUT_FULL;
            end
        end
        else
        begin
            if (rd_status == ST_EMPTY)
            begin
                probe_done    = 1'b1;
                probe_outcome = OUT_NOT_FOUND;
            end
            else if ((rd_status == ST_OCCUPIED) && (rd_key == key_reg))
            begin
                probe_done    = 1'b1;
                probe_outcome = OUT_OK;
                if (action_reg == ACT_REMOVE)
                begin
                    probe_write   = 1'b1;
                    probe_wstatus = ST_REMOVED;
                end
            end
            else if (last_probe)
            begin
                probe_done    = 1'b1;
                probe_outcome = OUT_NOT_FOUND;
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if ((action == ACT_INSERT) || (action == ACT_SEARCH) ||
                        (action == ACT_REMOVE))
                    begin
                        state_next = S_DIVIDE;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_DIVIDE:
            begin
                if (bit_reg == BIT_W'(KEY_W - 1))
                begin
                    state_next = S_FIXUP;
                end
            end
            S_FIXUP:
            begin
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                if (probe_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath, memory write port and result register.
    always_comb
    begin
        clr_next         = clr_reg;
        bit_next         = bit_reg;
        n_next           = n_reg;
        action_next      = action_reg;
        key_next         = key_reg;
        neg_next         = neg_reg;
        div_next         = div_reg;
        rem_next         = rem_reg;
        j_next           = j_reg;
        res_outcome_next = res_outcome_reg;
        res_slot_next    = res_slot_reg;
        outcome_next     = outcome_reg;
        slot_index_next  = slot_index_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        mem_we           = 1'b0;
        mem_waddr        = j_reg;
        mem_wdata        = {probe_wstatus, key_reg};

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = {ST_EMPTY, {KEY_W{1'b0}}};
                clr_next  = clr_reg + IDX_W'(1);
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    action_next      = action;
                    key_next         = key_u;
                    neg_next         = key_u[KEY_W-1];
                    div_next         = key_u[KEY_W-1] ? (~key_u + KEY_W'(1)) : key_u;
                    rem_next         = '0;
                    bit_next         = '0;
                    res_outcome_next = OUT_NOT_FOUND;
                    res_slot_next    = '0;
                end
            end
            S_DIVIDE:
            begin
                div_next = {div_reg[KEY_W-2:0], 1'b0};
                bit_next = bit_reg + BIT_W'(1);
                if (rem_trial >= {1'b0, m_size})
                begin
                    rem_next = CFG_W'(rem_trial - {1'b0, m_size});
                end
                else
                begin
                    rem_next = rem_trial[CFG_W-1:0];
                end
            end
            S_FIXUP:
            begin
                // Reading at j_next makes the home slot's word ready on entry to probing.
                j_next = IDX_W'(home_slot);
                n_next = '0;
            end
            S_PROBE:
            begin
                if (probe_done)
                begin
                    mem_we           = probe_write;
                    res_outcome_next = probe_outcome;
                    res_slot_next    = (probe_outcome == OUT_OK) ? j_reg : '0;
                end
                else
                begin
                    j_next = j_adv;
                    n_next = n_reg + CNT_W'(1);
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    outcome_next    = res_outcome_reg;
                    slot_index_next = SLOT_W'(res_slot_reg);
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            table_size_reg <= CFG_RESET;
            clr_reg        <= '0;
            bit_reg        <= '0;
            n_reg          <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            bit_reg       <= bit_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                table_size_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg      <= action_next;
        key_reg         <= key_next;
        neg_reg         <= neg_next;
        div_reg         <= div_next;
        rem_reg         <= rem_next;
        j_reg           <= j_next;
        res_outcome_reg <= res_outcome_next;
        res_slot_reg    <= res_slot_next;
        outcome_reg     <= outcome_next;
        slot_index_reg  <= slot_index_next;
    end

    // Slot memory.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        rd_q <= slot_mem[j_next];
    end

    assign out_valid  = out_valid_reg;
    assign outcome    = outcome_reg;
    assign slot_index = slot_index_reg;

    `ASSERT_AT(a_probe_in_range, clk, rst_n, (state_reg == S_PROBE) |-> ((CNT_W'(j_reg) < CNT_W'(m_size)) && (n_reg < CNT_W'(m_size))), "probe slot or probe count beyond the active size")
    `ASSERT_AT(a_rem_below_size, clk, rst_n, (state_reg == S_DIVIDE) |-> (rem_reg < m_size), "partial remainder not below the active size")
    `ASSERT_AT(a_one_at_a_time, clk, rst_n, (in_valid && in_ready) |=> !in_ready, "request accepted while another is in work")
    `ASSERT_NEVER(a_fail_slot_zero, clk, rst_n, out_valid_reg && (outcome_reg != OUT_OK) && (slot_index_reg != '0), "failed result carries a nonzero slot")
    `ASSERT_NEVER(a_no_result_in_clear, clk, rst_n, (state_reg == S_CLEAR) && out_valid_reg, "result shown during the clearing pass")

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for linear_probe_hash_table: directed rows, then random phases.
// Depends on lpht_pkg and the linear_probe_hash_table RTL; reads no files.
// A shadow copy of the slot table predicts every answer beat not typed in a directed row.
`default_nettype none

module tb;
    import lpht_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 128;

    // The package names three request codes; the fourth one is legal on the port and
    // must answer "not found" without touching the table.
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    localparam int DIRECTED_N = 24;
    localparam int PHASE_N = 12;

    // Mode of each random phase: index modulo four picks who idles.
    localparam int MODE_NONE = 0;
    localparam int MODE_SENDER = 1;
    localparam int MODE_RECEIVER = 2;
    localparam int MODE_BOTH = 3;

    typedef struct packed {
        logic [OUT_W-1:0]  outcome;
        logic [SLOT_W-1:0] slot;
    } answer_t;

    // One directed request. When cfg_first is set, table_size is rewritten (with the
    // block drained) before the request goes out. When fixed is set, the answer is
    // the one typed in the row instead of the shadow table's prediction.
    typedef struct packed {
        bit                cfg_first;
        logic [CFG_W-1:0]  cfg_value;
        logic [ACT_W-1:0]  act;
        logic [KEY_W-1:0]  k;
        bit                fixed;
        answer_t           answer;
    } request_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_write;
    logic [CFG_W-1:0]   cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [ACT_W-1:0]   req_action;
    logic [KEY_W-1:0]   req_key;
    logic               out_valid;
    logic               out_ready;
    logic [OUT_W-1:0]   outcome;
    logic [SLOT_W-1:0]  slot_index;

    // Shadow of the block's state. The key of a slot is only ever compared while the
    // slot is occupied, so its value before the first write never matters.
    logic [KEY_W-1:0]   shadow_key [DEPTH];
    logic [ST_W-1:0]    shadow_state [DEPTH];
    logic [CFG_W-1:0]   shadow_size;

    // Answers still owed by the block, oldest first.
    answer_t            pending_answers [$];
    // Keys that were sent with an insert; searches and removes draw from here so that
    // nearly half of them can hit.
    logic [KEY_W-1:0]   inserted_keys [$];

    int                 mismatch_count = 0;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    int                 hold_len = 0;
    int                 hold_seq = 0;

    // Directed part. The typed answers are the ones that are obvious: an empty table,
    // the unused request code, and the first two inserts at the reset size of 128.
    request_row_t directed_rows [DIRECTED_N] = '{
        // Empty table after reset: search and remove miss, the unused code misses.
        '{1'b0, 8'd0,   ACT_SEARCH, 32'h0000_0000, 1'b1, '{OUT_NOT_FOUND, 7'd0}},
        '{1'b0, 8'd0,   ACT_REMOVE, 32'h7FFF_FFFF, 1'b1, '{OUT_NOT_FOUND, 7'd0}},
        '{1'b0, 8'd0,   ACT_UNUSED, 32'h1234_5678, 1'b1, '{OUT_NOT_FOUND, 7'd0}},
        // Zero lands in slot 0, minus one wraps to the top slot.
        '{1'b0, 8'd0,   ACT_INSERT, 32'h0000_0000, 1'b1, '{OUT_OK, 7'd0}},
        '{1'b0, 8'd0,   ACT_INSERT, 32'hFFFF_FFFF, 1'b1, '{OUT_OK, 7'd127}},
        // Largest and smallest keys collide with those two and probe onward.
        '{1'b0, 8'd0,   ACT_INSERT, 32'h7FFF_FFFF, 1'b0, '0},
        '{1'b0, 8'd0,   ACT_INSERT, 32'h8000_0000, 1'b0, '0},
        '{1'b0, 8'd0,   ACT_SEARCH, 32'h7FFF_FFFF, 1'b0, '0},
        '{1'b0, 8'd0,   ACT_SEARCH, 32'h8000_0000, 1'b0, '0},
        // A duplicate key, then removing the first copy exposes the second.
        '{1'b0, 8'd0,   ACT_INSERT, 32'h0000_0000, 1'b0, '0},
        '{1'b0, 8'd0,   ACT_REMOVE, 32'h0000_0000, 1'b0, '0},
        '{1'b0, 8'd0,   ACT_SEARCH, 32'h0000_0000, 1'b0, '0},
        '{1'b0, 8'd0,   ACT_UNUSED, 32'hFFFF_FFFF, 1'b1, '{OUT_NOT_FOUND, 7'd0}},
        // Searches must step over tombstones and stop at the first empty slot.
        '{1'b0, 8'd0,   ACT_REMOVE, 32'h8000_0000, 1'b0, '0},
        '{1'b0, 8'd0,   ACT_SEARCH, 32'h8000_0000, 1'b0, '0},
        '{1'b0, 8'd0,   ACT_SEARCH, 32'h0000_0080, 1'b0, '0},
        '{1'b0, 8'd0,   ACT_INSERT, 32'hAAAA_AAAA, 1'b0, '0},
        '{1'b0, 8'd0,   ACT_INSERT, 32'h5555_5555, 1'b0, '0},
        '{1'b0, 8'd0,   ACT_SEARCH, 32'hAAAA_AAAA, 1'b0, '0},
        // A size of zero behaves as one slot, which now holds a tombstone: full.
        '{1'b1, 8'd0,   ACT_INSERT, 32'h0000_004D, 1'b0, '0},
        '{1'b0, 8'd0,   ACT_SEARCH, 32'h0000_004D, 1'b0, '0},
        // A size above the depth is clipped to the depth.
        '{1'b1, 8'd255, ACT_INSERT, 32'hFFFF_FFFB, 1'b0, '0},
        '{1'b0, 8'd0,   ACT_SEARCH, 32'hFFFF_FFFB, 1'b0, '0},
        // Shrunk to one slot: keys beyond slot 0 are kept but never probed.
        '{1'b1, 8'd1,   ACT_SEARCH, 32'h7FFF_FFFF, 1'b0, '0}
    };

    // Random phases: table size and number of requests. The small sizes come early and
    // between large ones so that collisions, tombstones and full tables all show up
    // before the slot budget runs out (tombstones are never reused).
    logic [CFG_W-1:0] phase_size [PHASE_N] = '{
        8'd7, 8'd3, 8'd13, 8'd0, 8'd40, 8'd255, 8'd2, 8'd100, 8'd128, 8'd1, 8'd64, 8'd128
    };
    int phase_items [PHASE_N] = '{
        150, 100, 200, 60, 250, 200, 80, 300, 300, 60, 200, 100
    };

    linear_probe_hash_table #(
        .TABLE_DEPTH(DEPTH)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (req_action),
        .key        (req_key),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .outcome    (outcome),
        .slot_index (slot_index)
    );

    always #5 clk = ~clk;

    // Number of slots actually probed: zero acts as one, anything above the depth is
    // clipped to the depth.
    function automatic int active_slots();
        if (shadow_size == 0)
            return 1;
        if (int'(shadow_size) > DEPTH)
            return DEPTH;
        return int'(shadow_size);
    endfunction

    // Applies one request to the shadow table and returns the answer the block owes.
    function automatic answer_t probe_shadow_table(logic [ACT_W-1:0] act,
                                                   logic [KEY_W-1:0] k);
        answer_t ans;
        int      m;
        int      j;
        longint  home;
        bit      hit;
        m = active_slots();
        // Signed remainder truncates toward zero; fold negatives back into range.
        home = longint'($signed(k)) % longint'(m);
        if (home < 0)
            home += m;
        j = int'(home);
        hit = 1'b0;
        ans.outcome = OUT_NOT_FOUND;
        ans.slot = '0;
        if (act == ACT_INSERT) begin
            ans.outcome = OUT_FULL;
            for (int n = 0; n < m; n++) begin
                if (shadow_state[j] == ST_EMPTY) begin
                    shadow_state[j] = ST_OCCUPIED;
                    shadow_key[j] = k;
                    ans.outcome = OUT_OK;
                    ans.slot = j[SLOT_W-1:0];
                    break;
                end
                j = (j + 1 >= m) ? 0 : j + 1;
            end
        end else if (act == ACT_SEARCH || act == ACT_REMOVE) begin
            for (int n = 0; n < m; n++) begin
                if (shadow_state[j] == ST_EMPTY)
                    break;
                if (shadow_state[j] == ST_OCCUPIED && shadow_key[j] == k) begin
                    hit = 1'b1;
                    break;
                end
                j = (j + 1 >= m) ? 0 : j + 1;
            end
            if (hit) begin
                ans.outcome = OUT_OK;
                ans.slot = j[SLOT_W-1:0];
                if (act == ACT_REMOVE) begin
                    shadow_key[j] = '1;
                    shadow_state[j] = ST_REMOVED;
                end
            end
        end
        return ans;
    endfunction

    // Picks a key for a random request. Nearly half reuse an inserted key so that
    // searches and removes hit; a quarter are spread so they share home slots.
    function automatic logic [KEY_W-1:0] pick_key();
        int     sel;
        int     m;
        longint v;
        sel = $urandom_range(0, 99);
        m = active_slots();
        if (sel < 45 && inserted_keys.size() > 0)
            return inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
        if (sel < 70) begin
            v = longint'($urandom_range(0, m - 1)) + longint'(m) * $urandom_range(0, 2000);
            if ($urandom_range(0, 1) == 1)
                v = -v;
            return v[KEY_W-1:0];
        end
        if (sel < 75) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'hFFFF_FFFF;
                default: return 32'h0000_0000;
            endcase
        end
        return $urandom;
    endfunction

    // Offers one request beat and waits until it is taken. Valid and payload hold
    // steady until the handshake; the sender may idle first, with valid low. The
    // answer is predicted at the edge where the beat is accepted.
    task automatic send_request(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] k,
                                input bit fixed, input answer_t fixed_answer);
        answer_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_action <= act;
        req_key <= k;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = probe_shadow_table(act, k);
        pending_answers.push_back(fixed ? fixed_answer : predicted);
        if (act == ACT_INSERT) begin
            inserted_keys.push_back(k);
            if (inserted_keys.size() > 48)
                void'(inserted_keys.pop_front());
        end
    endtask

    // Drops valid and waits until every owed answer beat has come back. Always spends
    // at least one edge so valid is never lowered and raised in the same step.
    task automatic drain_answers();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_answers.size() != 0)
            @(posedge clk);
    endtask

    // Rewrites table_size with the block drained. Every request yields an answer, so
    // an empty answer queue means nothing is in flight.
    task automatic write_table_size(input logic [CFG_W-1:0] value);
        drain_answers();
        repeat (2) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= value;
        shadow_size = value;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Receiver. Unless held, out_ready is redrawn every cycle from the stall rate. A hold
    // request from the main process forces it low while hold_left counts down.
    initial begin : receiver
        int seen_seq;
        int hold_left;
        seen_seq = 0;
        hold_left = 0;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_seq != seen_seq) begin
                seen_seq = hold_seq;
                hold_left = hold_len;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Answer checker: every accepted answer beat is matched against the oldest owed
    // answer, field by field.
    always @(posedge clk) begin : answer_check
        answer_t want;
        if (rst_n === 1'b1 && out_valid && out_ready) begin
            if (pending_answers.size() == 0) begin
                $error("answer beat with nothing owed: outcome %0d slot_index %0d",
                       outcome, slot_index);
                mismatch_count++;
            end else begin
                want = pending_answers.pop_front();
                if (outcome !== want.outcome) begin
                    $error("outcome: expected %0d, got %0d", want.outcome, outcome);
                    mismatch_count++;
                end
                if (slot_index !== want.slot) begin
                    $error("slot_index: expected %0d, got %0d", want.slot, slot_index);
                    mismatch_count++;
                end
            end
        end
    end

    // Hard stop far beyond the slowest legal run (about 2000 requests, each with a full
    // remainder pass and a probe of up to the whole table, plus idling and the long hold).
    initial begin : watchdog
        #40_000_000;
        $display("linear_probe_hash_table verification failed");
        $finish;
    end

    // Main sequence: reset, directed rows, then the random phases.
    initial begin : stimulus
        logic [ACT_W-1:0] act;
        int               sel;
        int               mode;
        for (int i = 0; i < DEPTH; i++) begin
            shadow_key[i] = '0;
            shadow_state[i] = ST_EMPTY;
        end
        shadow_size = CFG_RESET;
        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        req_action <= ACT_INSERT;
        req_key <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // The block clears its memory for a while after reset; the first request
        // simply waits for in_ready.
        foreach (directed_rows[i]) begin
            if (directed_rows[i].cfg_first)
                write_table_size(directed_rows[i].cfg_value);
            send_request(directed_rows[i].act, directed_rows[i].k,
                         directed_rows[i].fixed, directed_rows[i].answer);
        end

        for (int p = 0; p < PHASE_N; p++) begin
            write_table_size(phase_size[p]);
            mode = p % 4;
            send_idle_pct = (mode == MODE_SENDER) ? 59 : (mode == MODE_BOTH) ? 35 : 0;
            recv_stall_pct = (mode == MODE_RECEIVER) ? 59 : (mode == MODE_BOTH) ? 35 : 0;
            // In one phase the receiver holds off long enough that one answer sits in
            // the output register, the next one finishes behind it, and the block
            // drops in_ready while the sender keeps offering.
            if (p == 4) begin
                hold_len = 600;
                hold_seq++;
            end
            for (int n = 0; n < phase_items[p]; n++) begin
                // In another phase the sender stops halfway until all answers are in.
                if (p == 5 && n == phase_items[p] / 2)
                    drain_answers();
                sel = $urandom_range(0, 99);
                if (sel < 35)
                    act = ACT_INSERT;
                else if (sel < 70)
                    act = ACT_SEARCH;
                else if (sel < 95)
                    act = ACT_REMOVE;
                else
                    act = ACT_UNUSED;
                send_request(act, pick_key(), 1'b0, '0);
            end
        end

        drain_answers();
        // Room for a stray extra answer beat to show up and be flagged.
        repeat (200) @(posedge clk);
        if (mismatch_count == 0)
            $display("linear_probe_hash_table verification clean");
        else
            $display("linear_probe_hash_table verification failed");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
+incdir+hw/rtl
hw/rtl/lpht_pkg.sv
hw/rtl/linear_probe_hash_table.sv
tb/tb.sv
